FILE: rtl/multi_axis_step_generator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-axis step generator
// Shared property forms, clocked on the rising edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_STEP_GENERATOR_DEFINES_SVH
`define MULTI_AXIS_STEP_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define MSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define MSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/msg_pkg.sv
// ----------------------------------------------------------------------------
// msg_pkg
// Types and fixed constants of the multi-axis step generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msg_pkg;

  localparam int NUM_AXES    = 3;
  localparam int IN_W        = 24;
  localparam int DELAY_W     = 16;
  localparam int ACCEL_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  localparam logic [DELAY_W-1:0] START_DELAY_RST  = 16'd1000;
  localparam logic [DELAY_W-1:0] CRUISE_DELAY_RST = 16'd200;
  localparam logic [ACCEL_W-1:0] ACCEL_STEP_RST   = 8'd1;

  // Item kind as carried on the input channel
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELAY  = 2'd0,
    REG_CRUISE_DELAY = 2'd1,
    REG_ACCEL_STEP   = 2'd2
  } reg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] cruise_delay;
    logic [ACCEL_W-1:0] accel_step;
  } cfg_t;

  // Fixed-width part of a classified item
  typedef struct packed {
    kind_e               kind;
    logic [NUM_AXES-1:0] dir;
    logic [NUM_AXES-1:0] home;
    logic [NUM_AXES-1:0] rear;
    logic [DELAY_W-1:0]  ramp_cfg;
  } item_hdr_t;

endpackage

FILE: rtl/msg_front.sv
// ----------------------------------------------------------------------------
// msg_front
// Classifies input transfers: step magnitudes, directions, major count and
// ramp length bound, then pushes the item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msg_front #(
  parameter int STEP_BITS = 24
) (
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_x_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_y_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_z_i,
  input  logic [msg_pkg::NUM_AXES-1:0]      home_switches_i,
  input  logic [msg_pkg::NUM_AXES-1:0]      rear_switches_i,
  input  msg_pkg::cfg_t                     cfg_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output msg_pkg::item_hdr_t                hdr_o,
  output logic [STEP_BITS-1:0]              major_o,
  output logic [msg_pkg::NUM_AXES*STEP_BITS-1:0] abs_o
);
  import msg_pkg::*;

  localparam int AW = (STEP_BITS > IN_W) ? STEP_BITS : IN_W;
  localparam logic [AW-1:0] STEP_MAX = AW'((64'd1 << STEP_BITS) - 64'd1);

  logic [IN_W-1:0]      delta [NUM_AXES];
  logic [IN_W-1:0]      mag   [NUM_AXES];
  logic [AW-1:0]        mag_ext [NUM_AXES];
  logic [STEP_BITS-1:0] mag_sat [NUM_AXES];
  logic [STEP_BITS-1:0] major;

  assign delta[0] = delta_x_i;
  assign delta[1] = delta_y_i;
  assign delta[2] = delta_z_i;

  // Take magnitudes, clip to the step range, find the major count
  always_comb begin
    major = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i]     = delta[i][IN_W-1] ? (~delta[i] + IN_W'(1)) : delta[i];
      mag_ext[i] = AW'(mag[i]);
      mag_sat[i] = (mag_ext[i] > STEP_MAX) ? STEP_MAX[STEP_BITS-1:0]
                                            : mag_ext[i][STEP_BITS-1:0];
      if (mag_sat[i] > major) begin
        major = mag_sat[i];
      end
    end
  end

  // Pack the classified item
  always_comb begin
    hdr_o.kind = kind_e'(kind_i);
    for (int i = 0; i < NUM_AXES; i++) begin
      hdr_o.dir[i] = !delta[i][IN_W-1] && (|delta[i]);
      abs_o[i*STEP_BITS +: STEP_BITS] = mag_sat[i];
    end
    hdr_o.home     = home_switches_i;
    hdr_o.rear     = rear_switches_i;
    hdr_o.ramp_cfg = (cfg_i.start_delay > cfg_i.cruise_delay)
                   ? (cfg_i.start_delay - cfg_i.cruise_delay) : '0;
  end

  assign major_o    = major;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

FILE: rtl/msg_fifo.sv
// ----------------------------------------------------------------------------
// msg_fifo
// Short queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (PTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == DEPTH_CNT);

endmodule

FILE: rtl/msg_back.sv
// ----------------------------------------------------------------------------
// msg_back
// Executes queued items: loads moves, times steps, runs the per-axis
// Bresenham accumulators, checks limit switches and ramps the step delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msg_back #(
  parameter int STEP_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msg_pkg::cfg_t                     cfg_i,
  input  logic                              q_valid_i,
  input  msg_pkg::item_hdr_t                hdr_i,
  input  logic [STEP_BITS-1:0]              major_i,
  input  logic [msg_pkg::NUM_AXES*STEP_BITS-1:0] abs_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [msg_pkg::NUM_AXES-1:0]      step_pulses_o,
  output logic [msg_pkg::NUM_AXES-1:0]      directions_o,
  output logic                              motors_enabled_o,
  output logic                              busy_res_o,
  output logic                              limit_stop_o
);
  import msg_pkg::*;

  localparam int SB = STEP_BITS;
  localparam int RW = (SB > DELAY_W) ? SB : DELAY_W;

  // Move state
  logic [DELAY_W-1:0]  delay_q, delay_d;
  logic [DELAY_W-1:0]  elapsed_q, elapsed_d;
  logic [SB-1:0]       acc_q [NUM_AXES];
  logic [SB-1:0]       acc_d [NUM_AXES];
  logic [SB-1:0]       abs_q [NUM_AXES];
  logic [SB-1:0]       abs_d [NUM_AXES];
  logic [NUM_AXES-1:0] dir_q, dir_d;
  logic [SB-1:0]       major_q, major_d;
  logic [SB-1:0]       accel_until_q, accel_until_d;
  logic [SB-1:0]       decel_from_q, decel_from_d;
  logic [SB:0]         steps_q, steps_d;
  logic                moving_q, moving_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [NUM_AXES-1:0] pulses_q, pulses_d;
  logic                stop_q, stop_d;

  // Tick datapath
  logic [DELAY_W-1:0]  elapsed_inc;
  logic                fire;
  logic [SB:0]         sum   [NUM_AXES];
  logic [SB:0]         wrap  [NUM_AXES];
  logic [NUM_AXES-1:0] hit;
  logic [NUM_AXES-1:0] blocked;
  logic                stopped;
  logic                do_accel;
  logic                do_decel;
  logic [DELAY_W:0]    accel_ext;
  logic [DELAY_W-1:0]  delay_dec;
  logic [DELAY_W:0]    delay_sum;
  logic [DELAY_W-1:0]  delay_inc;
  logic [SB:0]         steps_inc;

  // Start datapath
  logic [RW-1:0]       ramp_bound;
  logic [RW-1:0]       major_half;
  logic [RW-1:0]       ramp;

  // Take a queued item whenever the result register is free or being drained
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Step timing, accumulators and delay ramp
  always_comb begin
    elapsed_inc = (elapsed_q == DELAY_MAX) ? DELAY_MAX : elapsed_q + DELAY_W'(1);
    fire        = (elapsed_inc >= delay_q);
    for (int i = 0; i < NUM_AXES; i++) begin
      sum[i]     = {1'b0, acc_q[i]} + {1'b0, abs_q[i]};
      hit[i]     = (sum[i] >= {1'b0, major_q});
      wrap[i]    = sum[i] - {1'b0, major_q};
      blocked[i] = hit[i] && (dir_q[i] ? hdr_i.rear[i] : hdr_i.home[i]);
    end
    stopped   = |blocked;
    // An abort sets the step count one past the major count
    do_accel  = !stopped && (steps_q < {1'b0, accel_until_q});
    do_decel  = stopped || (steps_q >= {1'b0, decel_from_q});
    accel_ext = (DELAY_W + 1)'(cfg_i.accel_step);
    delay_dec = ({1'b0, delay_q} > accel_ext + (DELAY_W + 1)'(1))
              ? delay_q - DELAY_W'(cfg_i.accel_step) : DELAY_W'(1);
    delay_sum = {1'b0, delay_q} + accel_ext;
    delay_inc = delay_sum[DELAY_W] ? DELAY_MAX : delay_sum[DELAY_W-1:0];
    steps_inc = (stopped ? {1'b0, major_q} : steps_q) + (SB + 1)'(1);
  end

  // Ramp length of a new move
  always_comb begin
    ramp_bound = RW'(hdr_i.ramp_cfg);
    major_half = RW'(major_i >> 1);
    ramp       = (ramp_bound > major_half) ? major_half : ramp_bound;
  end

  // Next move state
  always_comb begin
    delay_d       = delay_q;
    elapsed_d     = elapsed_q;
    acc_d         = acc_q;
    abs_d         = abs_q;
    dir_d         = dir_q;
    major_d       = major_q;
    accel_until_d = accel_until_q;
    decel_from_d  = decel_from_q;
    steps_d       = steps_q;
    moving_d      = moving_q;
    pulses_d      = '0;
    stop_d        = 1'b0;
    if (pop_o) begin
      unique case (hdr_i.kind)
        KIND_START: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            abs_d[i] = abs_i[i*SB +: SB];
            acc_d[i] = '0;
          end
          dir_d         = hdr_i.dir;
          major_d       = major_i;
          delay_d       = cfg_i.start_delay;
          accel_until_d = ramp[SB-1:0];
          decel_from_d  = major_i - ramp[SB-1:0];
          steps_d       = '0;
          elapsed_d     = DELAY_MAX;
          moving_d      = (major_i != '0);
        end
        KIND_TICK: begin
          if (moving_q) begin
            elapsed_d = elapsed_inc;
            if (fire) begin
              elapsed_d = '0;
              for (int i = 0; i < NUM_AXES; i++) begin
                acc_d[i] = hit[i] ? wrap[i][SB-1:0] : sum[i][SB-1:0];
              end
              pulses_d = hit & ~blocked;
              stop_d   = stopped;
              if (do_accel) begin
                delay_d = delay_dec;
              end else if (do_decel) begin
                delay_d = delay_inc;
              end
              steps_d  = steps_inc;
              moving_d = !stopped && (steps_inc < {1'b0, major_q});
            end
          end
        end
        default: begin
          moving_d = moving_q;
        end
      endcase
    end
  end

  // Hold the result until it is taken
  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q       <= '0;
      elapsed_q     <= '0;
      dir_q         <= '0;
      major_q       <= '0;
      accel_until_q <= '0;
      decel_from_q  <= '0;
      steps_q       <= '0;
      moving_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        acc_q[i] <= '0;
        abs_q[i] <= '0;
      end
    end else begin
      delay_q       <= delay_d;
      elapsed_q     <= elapsed_d;
      dir_q         <= dir_d;
      major_q       <= major_d;
      accel_until_q <= accel_until_d;
      decel_from_q  <= decel_from_d;
      steps_q       <= steps_d;
      moving_q      <= moving_d;
      out_valid_q   <= out_valid_d;
      acc_q         <= acc_d;
      abs_q         <= abs_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pulses_q <= pulses_d;
      stop_q   <= stop_d;
    end
  end

  logic [NUM_AXES-1:0] dir_out_q;
  logic                en_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dir_out_q <= dir_d;
      en_q      <= moving_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pulses_o    = pulses_q;
  assign directions_o     = dir_out_q;
  assign motors_enabled_o = en_q;
  assign busy_res_o       = en_q;
  assign limit_stop_o     = stop_q;

endmodule

FILE: rtl/multi_axis_step_generator.sv
// ----------------------------------------------------------------------------
// multi_axis_step_generator
// Three-axis Bresenham step generator with a trapezoid delay ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): kind_i = 0 starts a move with
//   signed counts delta_x/y/z; kind_i = 1 is one time tick. Switch levels
//   travel with every transfer and are checked on ticks that step.
//   Output channel (out_valid_o / out_stall_i): exactly one result per input
//   transfer, in order: step pulses, direction bits, driver enable, busy and
//   limit abort flag.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 start delay, 1 cruise delay, 2 accel step); other indexes are ignored.
//   Write only while the block is idle.
//   A result is registered: the item is first written into the queue, then
//   popped into the result register, which holds it until it is taken.
//   Throughput: one item per cycle while out_stall_i is low; the step logic
//   updates all move state at once, so items follow each other with no gap.
//   Reset: configuration takes its defaults, the move is idle, the queue and
//   result register are empty.
//   Stall: the result register holds while out_stall_i is high; the
//   four-entry queue keeps taking items until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_axis_step_generator_defines.svh"

module multi_axis_step_generator #(
  parameter int STEP_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [msg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_x_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_y_i,
  input  logic signed [msg_pkg::IN_W-1:0]   delta_z_i,
  input  logic [msg_pkg::NUM_AXES-1:0]      home_switches_i,
  input  logic [msg_pkg::NUM_AXES-1:0]      rear_switches_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [msg_pkg::NUM_AXES-1:0]      step_pulses_o,
  output logic [msg_pkg::NUM_AXES-1:0]      directions_o,
  output logic                              motors_enabled_o,
  output logic                              busy_res_o,
  output logic                              limit_stop_o
);
  import msg_pkg::*;

  localparam int HDR_W  = $bits(item_hdr_t);
  localparam int ITEM_W = HDR_W + (NUM_AXES + 1) * STEP_BITS;

  cfg_t cfg_q, cfg_d;

  logic                          push;
  logic                          pop;
  logic                          q_valid;
  logic                          q_full;
  item_hdr_t                     f_hdr;
  logic [STEP_BITS-1:0]          f_major;
  logic [NUM_AXES*STEP_BITS-1:0] f_abs;
  logic [ITEM_W-1:0]             q_wdata;
  logic [ITEM_W-1:0]             q_rdata;
  item_hdr_t                     b_hdr;
  logic [STEP_BITS-1:0]          b_major;
  logic [NUM_AXES*STEP_BITS-1:0] b_abs;

  // Configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_DELAY:  cfg_d.start_delay  = cfg_wdata_i;
        REG_CRUISE_DELAY: cfg_d.cruise_delay = cfg_wdata_i;
        REG_ACCEL_STEP:   cfg_d.accel_step   = cfg_wdata_i[ACCEL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay  <= START_DELAY_RST;
      cfg_q.cruise_delay <= CRUISE_DELAY_RST;
      cfg_q.accel_step   <= ACCEL_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify input transfers
  msg_front #(
    .STEP_BITS(STEP_BITS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .delta_x_i       (delta_x_i),
    .delta_y_i       (delta_y_i),
    .delta_z_i       (delta_z_i),
    .home_switches_i (home_switches_i),
    .rear_switches_i (rear_switches_i),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .hdr_o           (f_hdr),
    .major_o         (f_major),
    .abs_o           (f_abs)
  );

  assign q_wdata = {f_hdr, f_major, f_abs};

  // Queue between front and back
  msg_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  assign b_hdr   = item_hdr_t'(q_rdata[ITEM_W-1 -: HDR_W]);
  assign b_major = q_rdata[NUM_AXES*STEP_BITS +: STEP_BITS];
  assign b_abs   = q_rdata[NUM_AXES*STEP_BITS-1:0];

  // Back: carry out moves and ticks
  msg_back #(
    .STEP_BITS(STEP_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .hdr_i            (b_hdr),
    .major_i          (b_major),
    .abs_i            (b_abs),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .step_pulses_o    (step_pulses_o),
    .directions_o     (directions_o),
    .motors_enabled_o (motors_enabled_o),
    .busy_res_o       (busy_res_o),
    .limit_stop_o     (limit_stop_o)
  );

  // Checks
  `MSG_ASSERT_IMPL(a_pop_needs_item, clk_i, rst_ni, pop, q_valid)
  `MSG_ASSERT_IMPL(a_abort_ends_move, clk_i, rst_ni, out_valid_o && limit_stop_o, !motors_enabled_o && !busy_res_o)
  `MSG_ASSERT_NEXT(a_pop_fills_result, clk_i, rst_ni, pop, out_valid_o)
  `MSG_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, q_valid)

endmodule
